// ===== rtl/bfbe_pkg.sv =====
package bfbe_pkg;

	localparam int HASH_W     = 64;
	localparam int IDX_W      = 16;
	localparam int COUNT_W    = 32;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;
	localparam int PROBE_W    = 5;

	// The 64-bit digest reduction retires this many dividend bits per cycle.
	localparam int RED_STEP   = 4;
	localparam int RED_CYCLES = HASH_W / RED_STEP;
	localparam int RED_CNT_W  = $clog2(RED_CYCLES);

	localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_QUERY = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SET   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_GET   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BITS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT = 1'd1;

	localparam logic [CFG_DATA_W-1:0] FILTER_BITS_RST = 17'd65536;
	localparam logic [PROBE_W-1:0]    PROBE_COUNT_RST = 5'd4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [HASH_W-1:0] hash_a;
		logic [HASH_W-1:0] hash_b;
		logic [IDX_W-1:0]  bit_pos;
	} in_t;

	typedef struct packed {
		logic               present;
		logic               status;
		logic [COUNT_W-1:0] keys_added;
	} out_t;

endpackage

// ===== rtl/bfbe_mod_unit.sv =====
module bfbe_mod_unit #(
	parameter int DIV_W = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bfbe_pkg::HASH_W-1:0] dividend,
	input  logic [DIV_W-1:0]            divisor,
	output logic                        done,
	output logic [DIV_W-1:0]            rem
);

	logic                           busy_q;
	logic                           done_q;
	logic [bfbe_pkg::RED_CNT_W-1:0] cnt_q;
	logic [bfbe_pkg::HASH_W-1:0]    dvd_q;
	logic [DIV_W-1:0]               div_q;
	logic [DIV_W-1:0]               rem_q;
	logic [DIV_W-1:0]               rem_next;

	// Restoring remainder, a few dividend bits per cycle. The partial
	// remainder stays below the divisor, so one compare and subtract per bit.
	always_comb begin
		logic [DIV_W-1:0] r;
		logic [DIV_W:0]   t;
		r = rem_q;
		t = '0;
		for (int j = 0; j < bfbe_pkg::RED_STEP; j++) begin
			t = {r, dvd_q[bfbe_pkg::HASH_W-1-j]};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			r = t[DIV_W-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bfbe_pkg::RED_CNT_W'(bfbe_pkg::RED_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << bfbe_pkg::RED_STEP;
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/bfbe_bit_ram.sv =====
module bfbe_bit_ram #(
	parameter int DEPTH  = 8192,
	parameter int ADDR_W = 13
) (
	input  logic              clk,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data
);

	logic [7:0] mem [DEPTH];

	// A read and a write of the same byte in one cycle return the old byte.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

// ===== rtl/bloom_filter_bit_engine.sv =====
// Bloom filter bit engine with double hashing.
// Input words arrive on in_valid/in_stall with the mode, two 64-bit key
// digests and a bit index; one result word per input word leaves on
// out_valid/out_stall. The block works on one word at a time and holds
// in_stall high while busy. A result sits in an output register, so the
// next input word is taken while an earlier result still waits.
// Steps per word, from acceptance to the result register:
//   add and query: the two digests are reduced in parallel, 4 bits per
//   cycle, then one read-modify-write of the byte memory per probe, with
//   the write of one probe forwarded to the read of the next.
//   set bit and get bit: one probe of the addressed byte.
//   out of range or unused modes: straight to the result register.
//   clear: one byte cleared per cycle.
// The next word can be taken in the cycle after the result register loads.
// After reset the store is swept to zero with in_stall high; configuration
// writes are taken. A stalled receiver holds the result; the block then
// finishes its current word and waits with in_stall high until the output
// register frees. The user must write configuration only while idle, through
// cfg_we/cfg_index/cfg_data; the block itself does not enforce this.
module bloom_filter_bit_engine #(
	parameter int MAX_FILTER_BITS = 65536,
	parameter int MAX_PROBES      = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  bfbe_pkg::in_t                   in_word,
	output logic                            out_valid,
	input  logic                            out_stall,
	output bfbe_pkg::out_t                  out_word,
	input  logic                            cfg_we,
	input  logic [bfbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bfbe_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int STORE_BYTES = (MAX_FILTER_BITS + 7) / 8;
	localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int POS_W       = $clog2(MAX_FILTER_BITS);
	localparam int N_W         = $clog2(MAX_FILTER_BITS + 1);
	localparam int SUM_W       = POS_W + 1;
	localparam int K_W         = $clog2(MAX_PROBES + 1);

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_DIV,
		ST_PROBE,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                           state_q;
	logic [bfbe_pkg::CFG_DATA_W-1:0]  bits_q;
	logic [bfbe_pkg::PROBE_W-1:0]     probes_q;
	logic [bfbe_pkg::COUNT_W-1:0]     count_q;
	logic [bfbe_pkg::MODE_W-1:0]      mode_q;
	logic [POS_W-1:0]                 pos_q;
	logic [POS_W-1:0]                 h2_q;
	logic [K_W-1:0]                   left_q;
	logic                             all_q;
	logic                             status_q;
	logic                             clr_res_q;
	logic [ADDR_W-1:0]                clr_addr_q;
	logic                             out_valid_q;
	bfbe_pkg::out_t                   out_q;

	logic                             valid_s2;
	logic [2:0]                       bit_s2;
	logic [ADDR_W-1:0]                addr_s2;
	logic                             fwd_hit_s2;
	logic [7:0]                       fwd_data_s2;

	logic [N_W-1:0]                   n_eff;
	logic [K_W-1:0]                   k_eff;
	logic                             start_red;
	logic                             done_a;
	logic                             done_b;
	logic [N_W-1:0]                   rem_a;
	logic [N_W-1:0]                   rem_b;
	logic [SUM_W-1:0]                 pos_sum;
	logic [POS_W-1:0]                 pos_next;
	logic                             write_op;
	logic                             read_op;
	logic [7:0]                       byte_eff;
	logic [ADDR_W-1:0]                rd_addr;
	logic [7:0]                       rd_data;
	logic                             wr_en;
	logic [ADDR_W-1:0]                wr_addr;
	logic [7:0]                       wr_data;
	logic                             out_free;
	logic [bfbe_pkg::COUNT_W-1:0]     count_next;

	always_comb begin
		if (bits_q == '0) begin
			n_eff = N_W'(1);
		end else if (32'(bits_q) > 32'(MAX_FILTER_BITS)) begin
			n_eff = N_W'(MAX_FILTER_BITS);
		end else begin
			n_eff = N_W'(bits_q);
		end
		if (probes_q == '0) begin
			k_eff = K_W'(1);
		end else if (32'(probes_q) > 32'(MAX_PROBES)) begin
			k_eff = K_W'(MAX_PROBES);
		end else begin
			k_eff = K_W'(probes_q);
		end
	end

	assign start_red = (state_q == ST_IDLE) && in_valid &&
		(in_word.mode inside {bfbe_pkg::MODE_ADD, bfbe_pkg::MODE_QUERY});

	bfbe_mod_unit #(.DIV_W(N_W)) u_red_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_red),
		.dividend(in_word.hash_a),
		.divisor (n_eff),
		.done    (done_a),
		.rem     (rem_a)
	);

	bfbe_mod_unit #(.DIV_W(N_W)) u_red_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_red),
		.dividend(in_word.hash_b | bfbe_pkg::HASH_W'(1)),
		.divisor (n_eff),
		.done    (done_b),
		.rem     (rem_b)
	);

	// Both terms stay below n, so the next probe needs one conditional subtract.
	always_comb begin
		pos_sum = {1'b0, pos_q} + {1'b0, h2_q};
		if (pos_sum >= SUM_W'(n_eff)) begin
			pos_next = POS_W'(pos_sum - SUM_W'(n_eff));
		end else begin
			pos_next = POS_W'(pos_sum);
		end
	end

	assign write_op = mode_q inside {bfbe_pkg::MODE_ADD, bfbe_pkg::MODE_SET};
	assign read_op  = mode_q inside {bfbe_pkg::MODE_QUERY, bfbe_pkg::MODE_GET};

	// The previous probe's write lands at the same edge as this probe's read,
	// so a read of that byte takes the written value instead.
	assign byte_eff = fwd_hit_s2 ? fwd_data_s2 : rd_data;
	assign rd_addr  = ADDR_W'(pos_q >> 3);

	always_comb begin
		if (state_q == ST_CLR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = valid_s2 && write_op;
			wr_addr = addr_s2;
			wr_data = byte_eff | (8'b1 << bit_s2);
		end
	end

	bfbe_bit_ram #(.DEPTH(STORE_BYTES), .ADDR_W(ADDR_W)) u_ram (
		.clk    (clk),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= (state_q == ST_PROBE);
		end
	end

	always_ff @(posedge clk) begin
		bit_s2      <= pos_q[2:0];
		addr_s2     <= rd_addr;
		fwd_hit_s2  <= wr_en && (wr_addr == rd_addr);
		fwd_data_s2 <= wr_data;
	end

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		count_next = count_q;
		if (clr_res_q) begin
			count_next = '0;
		end else if ((mode_q == bfbe_pkg::MODE_ADD) && (count_q != bfbe_pkg::COUNT_MAX)) begin
			count_next = count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			bits_q      <= bfbe_pkg::FILTER_BITS_RST;
			probes_q    <= bfbe_pkg::PROBE_COUNT_RST;
			count_q     <= '0;
			clr_res_q   <= 1'b0;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bfbe_pkg::CFG_FILTER_BITS: bits_q   <= cfg_data;
					bfbe_pkg::CFG_PROBE_COUNT: probes_q <= cfg_data[bfbe_pkg::PROBE_W-1:0];
					default: ;
				endcase
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(STORE_BYTES - 1)) begin
						state_q <= clr_res_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						mode_q    <= in_word.mode;
						clr_res_q <= (in_word.mode == bfbe_pkg::MODE_CLEAR);
						case (in_word.mode)
							bfbe_pkg::MODE_ADD, bfbe_pkg::MODE_QUERY: begin
								all_q    <= 1'b1;
								status_q <= 1'b0;
								left_q   <= k_eff;
								state_q  <= ST_DIV;
							end
							bfbe_pkg::MODE_CLEAR: begin
								all_q      <= 1'b1;
								status_q   <= 1'b0;
								clr_addr_q <= '0;
								state_q    <= ST_CLR;
							end
							bfbe_pkg::MODE_SET, bfbe_pkg::MODE_GET: begin
								if (32'(in_word.bit_pos) >= 32'(n_eff)) begin
									status_q <= 1'b1;
									all_q    <= 1'b0;
									state_q  <= ST_DONE;
								end else begin
									status_q <= 1'b0;
									all_q    <= 1'b1;
									pos_q    <= POS_W'(in_word.bit_pos);
									h2_q     <= '0;
									left_q   <= K_W'(1);
									state_q  <= ST_PROBE;
								end
							end
							default: begin
								all_q    <= 1'b1;
								status_q <= 1'b0;
								state_q  <= ST_DONE;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (done_a && done_b) begin
						pos_q   <= POS_W'(rem_a);
						h2_q    <= POS_W'(rem_b);
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (valid_s2 && read_op) begin
						all_q <= all_q & byte_eff[bit_s2];
					end
					pos_q  <= pos_next;
					left_q <= left_q - 1'b1;
					if (left_q == K_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (read_op) begin
						all_q <= all_q & byte_eff[bit_s2];
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						count_q             <= count_next;
						out_q.present       <= read_op && !clr_res_q && all_q;
						out_q.status        <= status_q;
						out_q.keys_added    <= count_next;
						clr_res_q           <= 1'b0;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

`ifndef NO_ASSERTIONS
	a_red_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done_a == done_b)
		else $error("digest reduction units out of step");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (SUM_W'(pos_q) < SUM_W'(n_eff)))
		else $error("probe position not below bit count");

	a_s2_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(state_q == ST_PROBE))
		else $error("memory data stage without a read issue");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (32'(wr_addr) < 32'(STORE_BYTES)))
		else $error("byte memory write beyond the store");
`endif

endmodule

// ===== sim/tb_bloom_filter_bit_engine.sv =====
module tb_bloom_filter_bit_engine;

	localparam int FILTER_MAX   = 65536;
	localparam int PROBE_MAX    = 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int CLEAR_BUDGET = 6;
	localparam int PHASES       = 9;
	localparam int PHASE_WORDS  = 45;
	localparam int PRINT_CAP    = 200;

	// Shadow copy of the filter: bit store, key count and settings.
	class bloom_shadow;
		bit                              filter_mem [0:FILTER_MAX-1];
		logic [bfbe_pkg::COUNT_W-1:0]    key_total;
		logic [bfbe_pkg::CFG_DATA_W-1:0] filter_bits;
		logic [bfbe_pkg::PROBE_W-1:0]    probe_count;
		bfbe_pkg::out_t                  answers_due [$];
		int                              mismatches;

		function new();
			key_total   = '0;
			filter_bits = bfbe_pkg::FILTER_BITS_RST;
			probe_count = bfbe_pkg::PROBE_COUNT_RST;
			mismatches  = 0;
		endfunction

		function int unsigned eff_bits();
			if (filter_bits == 0) return 1;
			if (filter_bits > FILTER_MAX) return FILTER_MAX;
			return 32'(filter_bits);
		endfunction

		function int unsigned eff_probes();
			if (probe_count == 0) return 1;
			if (probe_count > PROBE_MAX) return PROBE_MAX;
			return 32'(probe_count);
		endfunction

		function int pending();
			return answers_due.size();
		endfunction

		function void write_setting(logic [bfbe_pkg::CFG_IDX_W-1:0] idx,
				logic [bfbe_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				bfbe_pkg::CFG_FILTER_BITS: filter_bits = data;
				bfbe_pkg::CFG_PROBE_COUNT: probe_count = data[bfbe_pkg::PROBE_W-1:0];
				default: ;
			endcase
		endfunction

		function bfbe_pkg::out_t predict_answer(bfbe_pkg::in_t w);
			longint unsigned n, h1, h2, pos;
			int unsigned     k, i;
			bit              all_set;
			bfbe_pkg::out_t  r;
			n = eff_bits();
			k = eff_probes();
			r = '0;
			case (w.mode)
				bfbe_pkg::MODE_ADD, bfbe_pkg::MODE_QUERY: begin
					h1 = w.hash_a % n;
					h2 = (w.hash_b | 64'd1) % n;
					all_set = 1'b1;
					for (i = 0; i < k; i++) begin
						pos = (h1 + 64'(i) * h2) % n;
						if (w.mode == bfbe_pkg::MODE_ADD) begin
							filter_mem[pos] = 1'b1;
						end else if (!filter_mem[pos]) begin
							all_set = 1'b0;
							break;
						end
					end
					if (w.mode == bfbe_pkg::MODE_ADD) begin
						if (key_total != bfbe_pkg::COUNT_MAX) key_total++;
					end else begin
						r.present = all_set;
					end
				end
				bfbe_pkg::MODE_CLEAR: begin
					foreach (filter_mem[j]) filter_mem[j] = 1'b0;
					key_total = '0;
				end
				bfbe_pkg::MODE_SET, bfbe_pkg::MODE_GET: begin
					if (w.bit_pos >= n) begin
						r.status = 1'b1;
					end else if (w.mode == bfbe_pkg::MODE_SET) begin
						filter_mem[w.bit_pos] = 1'b1;
					end else begin
						r.present = filter_mem[w.bit_pos];
					end
				end
				default: ;
			endcase
			r.keys_added = key_total;
			return r;
		endfunction

		function void note_word(bfbe_pkg::in_t w);
			answers_due.push_back(predict_answer(w));
		endfunction

		task report_mismatch(string what, longint unsigned got, longint unsigned want);
			// Printing is capped so a broken block cannot flood the log.
			if (mismatches < PRINT_CAP)
				$display("MISMATCH %s: got %0h expected %0h", what, got, want);
			mismatches++;
		endtask

		task check_word(bfbe_pkg::out_t got);
			bfbe_pkg::out_t want;
			if (answers_due.size() == 0) begin
				report_mismatch("result with nothing outstanding", got.keys_added, 0);
				return;
			end
			want = answers_due.pop_front();
			if (got.present !== want.present)
				report_mismatch("present", got.present, want.present);
			if (got.status !== want.status)
				report_mismatch("status", got.status, want.status);
			if (got.keys_added !== want.keys_added)
				report_mismatch("keys_added", got.keys_added, want.keys_added);
		endtask
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	bfbe_pkg::in_t                   in_word = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	bfbe_pkg::out_t                  out_word;
	logic                            cfg_we = 1'b0;
	logic [bfbe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bfbe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	bloom_shadow  board = new();
	bit           calm = 1'b0;
	int           clears_left = CLEAR_BUDGET;
	int           cycles = 0;
	logic [127:0] known_keys [$];

	bloom_filter_bit_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [bfbe_pkg::HASH_W-1:0] rand_digest();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic bfbe_pkg::in_t compose_word(logic [bfbe_pkg::MODE_W-1:0] mode,
			logic [bfbe_pkg::HASH_W-1:0] ha, logic [bfbe_pkg::HASH_W-1:0] hb,
			logic [bfbe_pkg::IDX_W-1:0] idx);
		bfbe_pkg::in_t w;
		w.mode    = mode;
		w.hash_a  = ha;
		w.hash_b  = hb;
		w.bit_pos = idx;
		return w;
	endfunction

	function automatic logic [bfbe_pkg::IDX_W-1:0] pick_index(int unsigned n);
		// Mostly in range, now and then anywhere in the 16-bit field.
		if ($urandom_range(0, 7) == 0) return bfbe_pkg::IDX_W'($urandom);
		return bfbe_pkg::IDX_W'($urandom_range(0, n - 1));
	endfunction

	function automatic bfbe_pkg::in_t random_word();
		bfbe_pkg::in_t w;
		int            pick;
		int unsigned   n;
		logic [127:0]  key;
		n = board.eff_bits();
		w = compose_word(bfbe_pkg::MODE_QUERY, rand_digest(), rand_digest(),
			bfbe_pkg::IDX_W'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			w.mode = bfbe_pkg::MODE_ADD;
			known_keys.push_back({w.hash_a, w.hash_b});
			if (known_keys.size() > 64) void'(known_keys.pop_front());
		end else if (pick < 40 && known_keys.size() > 0) begin
			w.mode = bfbe_pkg::MODE_ADD;
			key = known_keys[$urandom_range(0, known_keys.size() - 1)];
			{w.hash_a, w.hash_b} = key;
		end else if (pick < 65) begin
			// Queries of added keys are what make a query's present come back high.
			if (known_keys.size() > 0 && $urandom_range(0, 2) != 0) begin
				key = known_keys[$urandom_range(0, known_keys.size() - 1)];
				{w.hash_a, w.hash_b} = key;
			end
		end else if (pick < 78) begin
			w.mode = bfbe_pkg::MODE_SET;
			w.bit_pos = pick_index(n);
		end else if (pick < 92) begin
			w.mode = bfbe_pkg::MODE_GET;
			w.bit_pos = pick_index(n);
		end else if (pick < 97) begin
			w.mode = bfbe_pkg::MODE_W'($urandom_range(5, 7));
		end else if (clears_left > 0) begin
			w.mode = bfbe_pkg::MODE_CLEAR;
			clears_left--;
			known_keys.delete();
		end
		return w;
	endfunction

	task automatic send_word(bfbe_pkg::in_t w);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		board.note_word(w);
	endtask

	task automatic drive_setting(logic [bfbe_pkg::CFG_IDX_W-1:0] idx,
			logic [bfbe_pkg::CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.write_setting(idx, data);
		cfg_we <= 1'b0;
	endtask

	// Result side: take words and, unless calm, stall in runs of random length.
	initial begin
		int run_left;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) board.check_word(out_word);
			if (run_left > 0) begin
				run_left--;
			end else if (calm) begin
				out_stall <= 1'b0;
				run_left = 16;
			end else if ($urandom_range(0, 1) != 0) begin
				out_stall <= 1'b1;
				run_left = pick_gap();
			end else begin
				out_stall <= 1'b0;
				run_left = $urandom_range(0, 6);
			end
		end
	end

	initial begin
		logic [bfbe_pkg::CFG_DATA_W-1:0] phase_bits [PHASES];
		logic [bfbe_pkg::PROBE_W-1:0]    phase_probes [PHASES];
		logic [bfbe_pkg::HASH_W-1:0]     ha, hb;
		int                              ph;
		phase_bits   = '{17'd65536, 17'd100, 17'd0, 17'h1FFFF, 17'd8, 17'd1, 17'd4096,
			17'd65536, 17'd517};
		phase_probes = '{5'd4, 5'd5, 5'd0, 5'd31, 5'd16, 5'd1, 5'd2, 5'd16, 5'd9};

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset settings, the first presented while the store sweep still runs.
		send_word(compose_word(bfbe_pkg::MODE_GET, '0, '0, 16'd0));
		send_word(compose_word(bfbe_pkg::MODE_SET, '0, '0, 16'd0));
		send_word(compose_word(bfbe_pkg::MODE_GET, '0, '0, 16'd0));
		send_word(compose_word(bfbe_pkg::MODE_SET, '1, '1, 16'hFFFF));
		send_word(compose_word(bfbe_pkg::MODE_GET, '1, '1, 16'hFFFF));
		send_word(compose_word(bfbe_pkg::MODE_GET, '0, '0, 16'd1));
		send_word(compose_word(bfbe_pkg::MODE_ADD, '0, '0, 16'd0));
		send_word(compose_word(bfbe_pkg::MODE_QUERY, '0, '0, 16'd0));
		send_word(compose_word(bfbe_pkg::MODE_QUERY, '1, '1, 16'hFFFF));
		send_word(compose_word(bfbe_pkg::MODE_ADD, '1, '1, 16'hFFFF));
		send_word(compose_word(bfbe_pkg::MODE_QUERY, '1, '1, 16'hFFFF));
		ha = {$urandom, $urandom};
		hb = {$urandom, $urandom};
		send_word(compose_word(bfbe_pkg::MODE_ADD, ha, hb, bfbe_pkg::IDX_W'($urandom)));
		send_word(compose_word(bfbe_pkg::MODE_QUERY, ha, hb, bfbe_pkg::IDX_W'($urandom)));
		send_word(compose_word(3'd5, rand_digest(), rand_digest(), bfbe_pkg::IDX_W'($urandom)));
		send_word(compose_word(3'd6, rand_digest(), rand_digest(), bfbe_pkg::IDX_W'($urandom)));
		send_word(compose_word(3'd7, rand_digest(), rand_digest(), bfbe_pkg::IDX_W'($urandom)));
		send_word(compose_word(bfbe_pkg::MODE_CLEAR, '0, '0, 16'd0));
		send_word(compose_word(bfbe_pkg::MODE_QUERY, '0, '0, 16'd0));
		send_word(compose_word(bfbe_pkg::MODE_GET, '0, '0, 16'd0));

		// A narrow filter: indexes at and above the bit count are refused.
		drive_setting(bfbe_pkg::CFG_FILTER_BITS, 17'd100);
		send_word(compose_word(bfbe_pkg::MODE_SET, '0, '0, 16'd100));
		send_word(compose_word(bfbe_pkg::MODE_GET, '0, '0, 16'hFFFF));
		send_word(compose_word(bfbe_pkg::MODE_SET, '0, '0, 16'd99));
		send_word(compose_word(bfbe_pkg::MODE_GET, '0, '0, 16'd99));
		send_word(compose_word(bfbe_pkg::MODE_ADD, ha, hb, 16'd0));
		send_word(compose_word(bfbe_pkg::MODE_QUERY, ha, hb, 16'd0));

		// Saturation of the key count needs 2**32 adds and is out of reach here.
		for (ph = 0; ph < PHASES; ph++) begin
			drive_setting(bfbe_pkg::CFG_FILTER_BITS, phase_bits[ph]);
			drive_setting(bfbe_pkg::CFG_PROBE_COUNT,
				bfbe_pkg::CFG_DATA_W'(phase_probes[ph]));
			calm = (ph % 3 == 2);
			repeat (PHASE_WORDS) send_word(random_word());
		end

		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
